>>> rtl/core/pmtws_pkg.sv
// shared types and constants of the traffic window statistics block
package pmtws_pkg;

    localparam int NOW_W      = 32;
    localparam int KIND_W     = 16;
    localparam int BYTES_W    = 32;
    localparam int CMD_W      = 2;
    localparam int WIN_W      = 2;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // slot divider digests this many bits of the timestamp per cycle
    localparam int SLOT_STEPS = 8;

    localparam logic [KIND_W-1:0] KIND_A_RESET = 16'd0;
    localparam logic [KIND_W-1:0] KIND_B_RESET = 16'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_KIND_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND_B = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_COUNT  = 2'd0,
        CMD_ERROR  = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_t;

    typedef enum logic [WIN_W-1:0] {
        WIN_MINUTE = 2'd0,
        WIN_SHORT  = 2'd1,
        WIN_ALL    = 2'd2
    } win_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_READ,
        S_MODIFY,
        S_WALK,
        S_DRAIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] stamp;
        logic [CNT_W-1:0] a_files;
        logic [CNT_W-1:0] a_bytes;
        logic [CNT_W-1:0] b_files;
        logic [CNT_W-1:0] b_bytes;
        logic [CNT_W-1:0] errors;
    } bucket_t;

    typedef struct packed {
        logic item_load;
        logic clear_step;
        logic rd_slot;
        logic wr_update;
        logic walk_init_minute;
        logic walk_init_short;
        logic walk_init_all;
        logic walk_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             slot_done;
        logic [CMD_W-1:0] cmd;
        logic             addr_top;
        logic             rem_one;
        win_t             win;
        logic             out_full;
    } dp_stat_t;

endpackage

>>> rtl/core/pmtws_ifs.sv
// valid/ready channels for command beats and report beats
interface pmtws_item_if;
    logic                              valid;
    logic                              ready;
    logic [pmtws_pkg::CMD_W-1:0]       cmd;
    logic [pmtws_pkg::NOW_W-1:0]       now_seconds;
    logic [pmtws_pkg::KIND_W-1:0]      message_kind;
    logic [pmtws_pkg::BYTES_W-1:0]     message_bytes;

    modport source (output valid, output cmd, output now_seconds, output message_kind,
                    output message_bytes, input ready);
    modport sink   (input valid, input cmd, input now_seconds, input message_kind,
                    input message_bytes, output ready);
endinterface

interface pmtws_result_if;
    logic                          valid;
    logic                          ready;
    logic [pmtws_pkg::WIN_W-1:0]   window;
    logic [pmtws_pkg::SUM_W-1:0]   kind_a_files;
    logic [pmtws_pkg::SUM_W-1:0]   kind_a_bytes;
    logic [pmtws_pkg::SUM_W-1:0]   kind_b_files;
    logic [pmtws_pkg::SUM_W-1:0]   kind_b_bytes;
    logic [pmtws_pkg::SUM_W-1:0]   all_bytes;
    logic [pmtws_pkg::SUM_W-1:0]   error_total;
    logic                          last;

    modport source (output valid, output window, output kind_a_files, output kind_a_bytes,
                    output kind_b_files, output kind_b_bytes, output all_bytes,
                    output error_total, output last, input ready);
    modport sink   (input valid, input window, input kind_a_files, input kind_a_bytes,
                    input kind_b_files, input kind_b_bytes, input all_bytes,
                    input error_total, input last, output ready);
endinterface

>>> rtl/core/pmtws_slot.sv
// bucket index unit: (now / bucket seconds) mod bucket count, several bits per cycle
module pmtws_slot #(
    parameter int BUCKET_COUNT   = 1440,
    parameter int BUCKET_SECONDS = 60
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [pmtws_pkg::NOW_W-1:0]        now_seconds,
    output logic                               done,
    output logic [$clog2(BUCKET_COUNT)-1:0]    slot
);

    localparam int IDX_W  = $clog2(BUCKET_COUNT);
    localparam int REM_W  = $clog2(BUCKET_SECONDS) + 1;
    localparam int ROUNDS = pmtws_pkg::NOW_W / pmtws_pkg::SLOT_STEPS;
    localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    logic [pmtws_pkg::NOW_W-1:0] now_reg, now_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [IDX_W-1:0]            mod_reg, mod_next;
    logic [RND_W-1:0]            rnd_reg;
    logic                        busy_reg;
    logic                        done_reg;

    // restoring division by the bucket width, quotient folded modulo the ring size
    always_comb
    begin
        logic [REM_W-1:0] r_v;
        logic [IDX_W-1:0] m_v;
        logic [REM_W:0]   t_v;
        logic [IDX_W:0]   w_v;
        logic             q_v;
        r_v = rem_reg;
        m_v = mod_reg;
        for (int i = 0; i < pmtws_pkg::SLOT_STEPS; i++)
        begin
            t_v = {r_v, now_reg[pmtws_pkg::NOW_W-1-i]};
            q_v = (t_v >= (REM_W+1)'(BUCKET_SECONDS));
            r_v = q_v ? REM_W'(t_v - (REM_W+1)'(BUCKET_SECONDS)) : REM_W'(t_v);
            w_v = {m_v, q_v};
            m_v = (w_v >= (IDX_W+1)'(BUCKET_COUNT)) ? IDX_W'(w_v - (IDX_W+1)'(BUCKET_COUNT))
                                                     : IDX_W'(w_v);
        end
        rem_next = r_v;
        mod_next = m_v;
        now_next = now_reg << pmtws_pkg::SLOT_STEPS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (rnd_reg == RND_W'(ROUNDS-1));
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(ROUNDS-1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            now_reg <= now_seconds;
            rem_reg <= '0;
            mod_reg <= '0;
        end
        else if (busy_reg)
        begin
            now_reg <= now_next;
            rem_reg <= rem_next;
            mod_reg <= mod_next;
        end
    end

    assign done = done_reg;
    assign slot = mod_reg;

endmodule

>>> rtl/core/pmtws_dp.sv
// datapath: bucket memory, update logic, walk counters, accumulators, result register
module pmtws_dp #(
    parameter int BUCKET_COUNT   = 1440,
    parameter int BUCKET_SECONDS = 60,
    parameter int SHORT_WINDOW   = 5,
    parameter int EXPIRY_SECONDS = 86400
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pmtws_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmtws_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [pmtws_pkg::CMD_W-1:0]          item_cmd,
    input  logic [pmtws_pkg::NOW_W-1:0]          item_now_seconds,
    input  logic [pmtws_pkg::KIND_W-1:0]         item_message_kind,
    input  logic [pmtws_pkg::BYTES_W-1:0]        item_message_bytes,
    input  pmtws_pkg::ctrl_cmd_t                 ctl,
    output pmtws_pkg::dp_stat_t                  stat,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [pmtws_pkg::WIN_W-1:0]          res_window,
    output logic [pmtws_pkg::SUM_W-1:0]          res_kind_a_files,
    output logic [pmtws_pkg::SUM_W-1:0]          res_kind_a_bytes,
    output logic [pmtws_pkg::SUM_W-1:0]          res_kind_b_files,
    output logic [pmtws_pkg::SUM_W-1:0]          res_kind_b_bytes,
    output logic [pmtws_pkg::SUM_W-1:0]          res_all_bytes,
    output logic [pmtws_pkg::SUM_W-1:0]          res_error_total,
    output logic                                 res_last
);

    localparam int IDX_W    = $clog2(BUCKET_COUNT);
    localparam int WALK_MAX = (BUCKET_COUNT > SHORT_WINDOW) ? BUCKET_COUNT : SHORT_WINDOW;
    localparam int WALK_W   = $clog2(WALK_MAX + 1);
    localparam int CNT_W    = pmtws_pkg::CNT_W;
    localparam int SUM_W    = pmtws_pkg::SUM_W;

    function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    // configuration
    logic [pmtws_pkg::KIND_W-1:0] kind_a_code_reg, kind_b_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_a_code_reg <= pmtws_pkg::KIND_A_RESET;
            kind_b_code_reg <= pmtws_pkg::KIND_B_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pmtws_pkg::CFG_KIND_A: kind_a_code_reg <= cfg_data;
                pmtws_pkg::CFG_KIND_B: kind_b_code_reg <= cfg_data;
            endcase
        end
    end

    // latched command beat
    logic [pmtws_pkg::CMD_W-1:0]   cmd_reg;
    logic [pmtws_pkg::NOW_W-1:0]   now_reg;
    logic [pmtws_pkg::KIND_W-1:0]  kind_reg;
    logic [pmtws_pkg::BYTES_W-1:0] bytes_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.item_load)
        begin
            cmd_reg   <= item_cmd;
            now_reg   <= item_now_seconds;
            kind_reg  <= item_message_kind;
            bytes_reg <= item_message_bytes;
        end
    end

    logic             slot_done;
    logic [IDX_W-1:0] slot;

    pmtws_slot #(
        .BUCKET_COUNT   (BUCKET_COUNT),
        .BUCKET_SECONDS (BUCKET_SECONDS)
    ) u_slot (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (ctl.item_load),
        .now_seconds (item_now_seconds),
        .done        (slot_done),
        .slot        (slot)
    );

    // bucket memory
    pmtws_pkg::bucket_t mem [BUCKET_COUNT];
    pmtws_pkg::bucket_t rd_data_reg;
    pmtws_pkg::bucket_t upd;
    pmtws_pkg::bucket_t mem_wdata;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    logic [IDX_W-1:0]   addr_reg;
    logic               rd_valid_reg;

    // read-modify-write of one bucket
    always_comb
    begin
        logic expired;
        logic hit_a;
        logic hit_b;
        upd     = rd_data_reg;
        expired = ({1'b0, rd_data_reg.stamp} + (CNT_W+1)'(EXPIRY_SECONDS))
                  <= {1'b0, now_reg};
        hit_a   = (kind_reg == kind_a_code_reg);
        hit_b   = !hit_a && (kind_reg == kind_b_code_reg);
        if (cmd_reg == pmtws_pkg::CMD_COUNT)
        begin
            if (expired)
            begin
                upd       = '0;
                upd.stamp = now_reg;
            end
            if (hit_a)
            begin
                upd.a_files = sat_add32(upd.a_files, CNT_W'(1));
                upd.a_bytes = sat_add32(upd.a_bytes, bytes_reg);
            end
            if (hit_b)
            begin
                upd.b_files = sat_add32(upd.b_files, CNT_W'(1));
                upd.b_bytes = sat_add32(upd.b_bytes, bytes_reg);
            end
        end
        else
        begin
            upd.errors = sat_add32(rd_data_reg.errors, CNT_W'(1));
        end
    end

    always_comb
    begin
        mem_we    = ctl.clear_step || ctl.wr_update;
        mem_waddr = ctl.clear_step ? addr_reg : slot;
        mem_wdata = ctl.clear_step ? '0 : upd;
        mem_raddr = ctl.walk_step ? addr_reg : slot;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // walk address, remaining count and window code
    logic [WALK_W-1:0] rem_reg;
    pmtws_pkg::win_t   win_reg;
    logic [IDX_W-1:0]  prev_slot, addr_dec;
    logic              addr_top;

    assign addr_top  = (addr_reg == IDX_W'(BUCKET_COUNT-1));
    assign prev_slot = (slot == '0) ? IDX_W'(BUCKET_COUNT-1) : slot - IDX_W'(1);
    assign addr_dec  = (addr_reg == '0) ? IDX_W'(BUCKET_COUNT-1) : addr_reg - IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rem_reg      <= '0;
            win_reg      <= pmtws_pkg::WIN_MINUTE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctl.walk_step;
            if (ctl.clear_step)
            begin
                addr_reg <= addr_top ? '0 : addr_reg + IDX_W'(1);
            end
            else if (ctl.walk_init_minute)
            begin
                addr_reg <= prev_slot;
                rem_reg  <= WALK_W'(1);
                win_reg  <= pmtws_pkg::WIN_MINUTE;
            end
            else if (ctl.walk_init_short)
            begin
                rem_reg <= WALK_W'(SHORT_WINDOW-1);
                win_reg <= pmtws_pkg::WIN_SHORT;
            end
            else if (ctl.walk_init_all)
            begin
                addr_reg <= IDX_W'(BUCKET_COUNT-1);
                rem_reg  <= WALK_W'(BUCKET_COUNT);
                win_reg  <= pmtws_pkg::WIN_ALL;
            end
            else if (ctl.walk_step)
            begin
                addr_reg <= addr_dec;
                rem_reg  <= rem_reg - WALK_W'(1);
            end
        end
    end

    // window accumulators
    logic [SUM_W-1:0] acc_af_reg, acc_ab_reg, acc_bf_reg, acc_bb_reg, acc_er_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.walk_init_minute || ctl.walk_init_all)
        begin
            acc_af_reg <= '0;
            acc_ab_reg <= '0;
            acc_bf_reg <= '0;
            acc_bb_reg <= '0;
            acc_er_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            acc_af_reg <= sat_add48(acc_af_reg, SUM_W'(rd_data_reg.a_files));
            acc_ab_reg <= sat_add48(acc_ab_reg, SUM_W'(rd_data_reg.a_bytes));
            acc_bf_reg <= sat_add48(acc_bf_reg, SUM_W'(rd_data_reg.b_files));
            acc_bb_reg <= sat_add48(acc_bb_reg, SUM_W'(rd_data_reg.b_bytes));
            acc_er_reg <= sat_add48(acc_er_reg, SUM_W'(rd_data_reg.errors));
        end
    end

    // result register
    logic res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res_window       <= win_reg;
            res_kind_a_files <= acc_af_reg;
            res_kind_a_bytes <= acc_ab_reg;
            res_kind_b_files <= acc_bf_reg;
            res_kind_b_bytes <= acc_bb_reg;
            res_all_bytes    <= sat_add48(acc_ab_reg, acc_bb_reg);
            res_error_total  <= acc_er_reg;
            res_last         <= (win_reg == pmtws_pkg::WIN_ALL);
        end
    end

    assign res_valid = res_valid_reg;

    always_comb
    begin
        stat.slot_done = slot_done;
        stat.cmd       = cmd_reg;
        stat.addr_top  = addr_top;
        stat.rem_one   = (rem_reg == WALK_W'(1));
        stat.win       = win_reg;
        stat.out_full  = res_valid_reg;
    end

endmodule

>>> rtl/core/pmtws_ctrl.sv
// controller: sequences clearing, bucket updates and report walks
module pmtws_ctrl #(
    parameter int SHORT_WINDOW = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic [pmtws_pkg::CMD_W-1:0]    item_cmd,
    output logic                           item_ready,
    input  pmtws_pkg::dp_stat_t            stat,
    output pmtws_pkg::ctrl_cmd_t           ctl
);

    pmtws_pkg::state_t state_reg, state_next;
    logic              item_known;

    assign item_known = (item_cmd == pmtws_pkg::CMD_COUNT)
                     || (item_cmd == pmtws_pkg::CMD_ERROR)
                     || (item_cmd == pmtws_pkg::CMD_REPORT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmtws_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmtws_pkg::S_CLEAR:
            begin
                if (stat.addr_top)
                    state_next = pmtws_pkg::S_IDLE;
            end
            pmtws_pkg::S_IDLE:
            begin
                if (item_valid && item_known)
                    state_next = pmtws_pkg::S_SLOT;
            end
            pmtws_pkg::S_SLOT:
            begin
                if (stat.slot_done)
                    state_next = (stat.cmd == pmtws_pkg::CMD_REPORT) ? pmtws_pkg::S_WALK
                                                                     : pmtws_pkg::S_READ;
            end
            pmtws_pkg::S_READ:   state_next = pmtws_pkg::S_MODIFY;
            pmtws_pkg::S_MODIFY: state_next = pmtws_pkg::S_IDLE;
            pmtws_pkg::S_WALK:
            begin
                if (stat.rem_one)
                    state_next = pmtws_pkg::S_DRAIN;
            end
            pmtws_pkg::S_DRAIN:  state_next = pmtws_pkg::S_EMIT;
            pmtws_pkg::S_EMIT:
            begin
                if (!stat.out_full)
                begin
                    unique case (stat.win)
                        pmtws_pkg::WIN_MINUTE:
                            state_next = (SHORT_WINDOW > 1) ? pmtws_pkg::S_WALK
                                                            : pmtws_pkg::S_EMIT;
                        pmtws_pkg::WIN_SHORT:  state_next = pmtws_pkg::S_WALK;
                        pmtws_pkg::WIN_ALL:    state_next = pmtws_pkg::S_IDLE;
                        default:               state_next = pmtws_pkg::S_IDLE;
                    endcase
                end
            end
            default: state_next = pmtws_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            pmtws_pkg::S_CLEAR:  ctl.clear_step = 1'b1;
            pmtws_pkg::S_IDLE:
            begin
                item_ready    = 1'b1;
                // an unused command is swallowed without starting the slot divider
                ctl.item_load = item_valid && item_known;
            end
            pmtws_pkg::S_SLOT:
            begin
                ctl.walk_init_minute = stat.slot_done && (stat.cmd == pmtws_pkg::CMD_REPORT);
            end
            pmtws_pkg::S_READ:   ctl.rd_slot   = 1'b1;
            pmtws_pkg::S_MODIFY: ctl.wr_update = 1'b1;
            pmtws_pkg::S_WALK:   ctl.walk_step = 1'b1;
            pmtws_pkg::S_DRAIN:  ctl = '0;
            pmtws_pkg::S_EMIT:
            begin
                if (!stat.out_full)
                begin
                    ctl.out_load = 1'b1;
                    unique case (stat.win)
                        pmtws_pkg::WIN_MINUTE: ctl.walk_init_short = 1'b1;
                        pmtws_pkg::WIN_SHORT:  ctl.walk_init_all   = 1'b1;
                        pmtws_pkg::WIN_ALL:    ctl.walk_init_all   = 1'b0;
                        default:               ctl.walk_init_all   = 1'b0;
                    endcase
                end
            end
            default: ctl = '0;
        endcase
    end

endmodule

>>> rtl/core/per_minute_traffic_window_stats_core.sv
// top level of the per-minute traffic window statistics block
//
//   channel   dir   beat carries                                         handshake
//   item      in    cmd, now_seconds, message_kind, message_bytes        valid/ready
//   result    out   window, four kind totals, all_bytes, error_total,    valid/ready
//                   last
//   cfg       in    cfg_index, cfg_data                                  cfg_we only
//
// count and error beats: the slot divider (four rounds of eight timestamp bits, then its
//   done pulse), one bucket read, one bucket write and a return to idle for the next beat
// report beats: slot divider, then SHORT_WINDOW + BUCKET_COUNT bucket reads, one per cycle
//   through the single bucket memory read port, plus a drain and an emit state per window
// after reset a clearing pass writes zeros to all BUCKET_COUNT buckets, one a cycle;
//   no item beat is taken meanwhile, configuration writes are
// a single result register sits on the output; a stalled sink holds the report walk
//   at the next window boundary, and the next item is taken while the final beat waits
module per_minute_traffic_window_stats_core #(
    parameter int BUCKET_COUNT   = 1440,
    parameter int BUCKET_SECONDS = 60,
    parameter int SHORT_WINDOW   = 5,
    parameter int EXPIRY_SECONDS = 86400
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pmtws_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmtws_pkg::CFG_DATA_W-1:0]   cfg_data,
    pmtws_item_if.sink                         item,
    pmtws_result_if.source                     result
);

    // command and status bundles between controller and datapath
    pmtws_pkg::ctrl_cmd_t ctl;
    pmtws_pkg::dp_stat_t  stat;
    logic                 item_ready;

    assign item.ready = item_ready;

    // controller: one beat in flight, walks windows in order minute, short, all
    pmtws_ctrl #(
        .SHORT_WINDOW (SHORT_WINDOW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_cmd   (item.cmd),
        .item_ready (item_ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    // datapath: bucket ring memory, slot divider, accumulators, result register
    pmtws_dp #(
        .BUCKET_COUNT   (BUCKET_COUNT),
        .BUCKET_SECONDS (BUCKET_SECONDS),
        .SHORT_WINDOW   (SHORT_WINDOW),
        .EXPIRY_SECONDS (EXPIRY_SECONDS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .item_cmd           (item.cmd),
        .item_now_seconds   (item.now_seconds),
        .item_message_kind  (item.message_kind),
        .item_message_bytes (item.message_bytes),
        .ctl                (ctl),
        .stat               (stat),
        .res_valid          (result.valid),
        .res_ready          (result.ready),
        .res_window         (result.window),
        .res_kind_a_files   (result.kind_a_files),
        .res_kind_a_bytes   (result.kind_a_bytes),
        .res_kind_b_files   (result.kind_b_files),
        .res_kind_b_bytes   (result.kind_b_bytes),
        .res_all_bytes      (result.all_bytes),
        .res_error_total    (result.error_total),
        .res_last           (result.last)
    );

    // a window total is only loaded into an empty result register
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !stat.out_full)
        else $error("result register overwritten while holding a beat");

    // the final beat of a report is exactly the all-buckets window
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.last == (result.window == pmtws_pkg::WIN_ALL)))
        else $error("last flag disagrees with window code");

    // slot divider completion is a single-cycle pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.slot_done |=> !stat.slot_done)
        else $error("slot done held for more than one cycle");

    // no item beat is taken while the bucket memory is written or walked
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.clear_step || ctl.wr_update || ctl.walk_step) |-> !item_ready)
        else $error("item accepted during bucket memory activity");

endmodule

>>> test/pmtws_window_checker.sv
// beat monitor with bucket ring predictor and report comparison for the window statistics block
module pmtws_window_checker
    import pmtws_pkg::*;
#(
    parameter int BUCKET_COUNT   = 1440,
    parameter int BUCKET_SECONDS = 60,
    parameter int SHORT_WINDOW   = 5,
    parameter int EXPIRY_SECONDS = 86400
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pmtws_item_if                 item,
    pmtws_result_if               result,
    output int                    mismatches,
    output int                    pending,
    output int                    reports_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        win_t             window;
        logic [SUM_W-1:0] a_files;
        logic [SUM_W-1:0] a_bytes;
        logic [SUM_W-1:0] b_files;
        logic [SUM_W-1:0] b_bytes;
        logic [SUM_W-1:0] all_bytes;
        logic [SUM_W-1:0] errors;
        logic             last;
    } totals_t;

    bucket_t           ring [BUCKET_COUNT];
    logic [KIND_W-1:0] code_a;
    logic [KIND_W-1:0] code_b;
    totals_t           totals_due [$];
    int                fail_count;
    int                beats_checked;

    function automatic logic [CNT_W-1:0] add_sat32(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] add_sat48(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic int slot_of_time(logic [NOW_W-1:0] t);
        longint unsigned t64;
        t64 = t;
        return int'((t64 / BUCKET_SECONDS) % BUCKET_COUNT);
    endfunction

    // walk backwards from first over len buckets, wrapping round the ring
    function automatic totals_t tally(win_t w, int first, int len);
        totals_t r;
        int      idx;
        int      i;
        r = '0;
        r.window = w;
        idx = first;
        for (i = 0; i < len; i++)
        begin
            r.a_files = add_sat48(r.a_files, SUM_W'(ring[idx].a_files));
            r.a_bytes = add_sat48(r.a_bytes, SUM_W'(ring[idx].a_bytes));
            r.b_files = add_sat48(r.b_files, SUM_W'(ring[idx].b_files));
            r.b_bytes = add_sat48(r.b_bytes, SUM_W'(ring[idx].b_bytes));
            r.errors  = add_sat48(r.errors, SUM_W'(ring[idx].errors));
            idx = (idx == 0) ? BUCKET_COUNT - 1 : idx - 1;
        end
        r.all_bytes = add_sat48(r.a_bytes, r.b_bytes);
        r.last = (w == WIN_ALL);
        return r;
    endfunction

    task automatic apply_beat();
        int              slot;
        int              prev;
        longint unsigned lapse_end;
        slot = slot_of_time(item.now_seconds);
        case (item.cmd)
            CMD_COUNT:
            begin
                // stale bucket: clear and restamp, compare done without wrap
                lapse_end = ring[slot].stamp;
                lapse_end += EXPIRY_SECONDS;
                if (lapse_end <= item.now_seconds)
                begin
                    ring[slot] = '0;
                    ring[slot].stamp = item.now_seconds;
                end
                if (item.message_kind == code_a)
                begin
                    ring[slot].a_files = add_sat32(ring[slot].a_files, 1);
                    ring[slot].a_bytes = add_sat32(ring[slot].a_bytes, item.message_bytes);
                end
                else if (item.message_kind == code_b)
                begin
                    ring[slot].b_files = add_sat32(ring[slot].b_files, 1);
                    ring[slot].b_bytes = add_sat32(ring[slot].b_bytes, item.message_bytes);
                end
            end
            CMD_ERROR:
                ring[slot].errors = add_sat32(ring[slot].errors, 1);
            CMD_REPORT:
            begin
                prev = (slot == 0) ? BUCKET_COUNT - 1 : slot - 1;
                totals_due.push_back(tally(WIN_MINUTE, prev, 1));
                totals_due.push_back(tally(WIN_SHORT, prev, SHORT_WINDOW));
                totals_due.push_back(tally(WIN_ALL, BUCKET_COUNT - 1, BUCKET_COUNT));
            end
            default:
                ;
        endcase
    endtask

    task automatic check_beat();
        totals_t seen;
        totals_t due;
        seen.window    = win_t'(result.window);
        seen.a_files   = result.kind_a_files;
        seen.a_bytes   = result.kind_a_bytes;
        seen.b_files   = result.kind_b_files;
        seen.b_bytes   = result.kind_b_bytes;
        seen.all_bytes = result.all_bytes;
        seen.errors    = result.error_total;
        seen.last      = result.last;
        beats_checked++;
        if (totals_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES)
                $display("%t report beat with nothing outstanding: window %0d",
                         $realtime, seen.window);
        end
        else
        begin
            due = totals_due.pop_front();
            if (seen !== due)
            begin
                fail_count++;
                if (fail_count <= SHOWN_MISMATCHES)
                begin
                    $display("%t report mismatch, expected win %0d af %0d ab %0d bf %0d bb %0d all %0d err %0d last %0d",
                             $realtime, due.window, due.a_files, due.a_bytes, due.b_files,
                             due.b_bytes, due.all_bytes, due.errors, due.last);
                    $display("%t report mismatch, actual   win %0d af %0d ab %0d bf %0d bb %0d all %0d err %0d last %0d",
                             $realtime, seen.window, seen.a_files, seen.a_bytes, seen.b_files,
                             seen.b_bytes, seen.all_bytes, seen.errors, seen.last);
                end
            end
        end
    endtask

    initial
    begin
        foreach (ring[i])
            ring[i] = '0;
        code_a = KIND_A_RESET;
        code_b = KIND_B_RESET;
        fail_count = 0;
        beats_checked = 0;
        mismatches = 0;
        pending = 0;
        reports_checked = 0;
    end

    // results first: they always belong to older commands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
                check_beat();
            if (item.valid && item.ready)
                apply_beat();
            if (cfg_we)
            begin
                if (cfg_index == CFG_KIND_A)
                    code_a = cfg_data;
                else
                    code_b = cfg_data;
            end
        end
        pending         <= totals_due.size();
        mismatches      <= fail_count;
        reports_checked <= beats_checked;
    end

endmodule

>>> test/per_minute_traffic_window_stats_core_test.sv
// top of the window statistics testbench: clock, reset, command stimulus and verdict
module per_minute_traffic_window_stats_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pmtws_pkg::*;

    localparam int BUCKET_COUNT   = 1440;
    localparam int BUCKET_SECONDS = 60;
    localparam int SHORT_WINDOW   = 5;
    localparam int EXPIRY_SECONDS = 86400;

    // cmd value the block must swallow without a result
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int MAX_GAP        = 16;
    // margin for a count or error beat to complete after acceptance
    localparam int SETTLE_CYCLES  = 32;
    // long result-side hold, well over one full report walk
    localparam int HOLD_CYCLES    = 2500;
    // clearing pass, a stalled report walk and the hold all fit several times over
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 62;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pmtws_item_if   item_ch ();
    pmtws_result_if result_ch ();

    int mismatches;
    int pending;
    int reports_checked;

    // steady and hold_len link command and result side; quiet_cycles is the watchdog's count
    logic steady = 1'b0;
    int   hold_len = 0;
    int   quiet_cycles = 0;

    // stimulus-side view of the codes and the traffic clock
    logic [KIND_W-1:0] code_a = KIND_A_RESET;
    logic [KIND_W-1:0] code_b = KIND_B_RESET;
    logic [NOW_W-1:0]  clock_now = '0;
    int                sent_count [4] = '{0, 0, 0, 0};
    int                settings_used = 0;

    per_minute_traffic_window_stats_core #(
        .BUCKET_COUNT   (BUCKET_COUNT),
        .BUCKET_SECONDS (BUCKET_SECONDS),
        .SHORT_WINDOW   (SHORT_WINDOW),
        .EXPIRY_SECONDS (EXPIRY_SECONDS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    pmtws_window_checker #(
        .BUCKET_COUNT   (BUCKET_COUNT),
        .BUCKET_SECONDS (BUCKET_SECONDS),
        .SHORT_WINDOW   (SHORT_WINDOW),
        .EXPIRY_SECONDS (EXPIRY_SECONDS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item            (item_ch),
        .result          (result_ch),
        .mismatches      (mismatches),
        .pending         (pending),
        .reports_checked (reports_checked)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog: cycles in which neither channel moves a beat
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                 quiet_cycles, pending);
        $display("per_minute_traffic_window_stats_core test failed");
        $finish;
    end

    // result side: a fresh stall per beat, a long hold when one is requested
    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_len > 0)
            begin
                // pressure: the block fills up behind this
                gap = hold_len;
                hold_len = 0;
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // one command beat; valid stays high straight into the next beat when there is no gap
    task automatic offer_beat(input logic [CMD_W-1:0] c, input logic [NOW_W-1:0] t,
                              input logic [KIND_W-1:0] k, input logic [BYTES_W-1:0] n);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.cmd           <= c;
        item_ch.now_seconds   <= t;
        item_ch.message_kind  <= k;
        item_ch.message_bytes <= n;
        do @(posedge clk); while (!item_ch.ready);
        sent_count[c]++;
    endtask

    // wait for every report beat, then let a trailing count or error beat finish
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_codes(input logic [KIND_W-1:0] a, input logic [KIND_W-1:0] b);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_KIND_A;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= CFG_KIND_B;
        cfg_data  <= b;
        @(posedge clk);
        cfg_we    <= 1'b0;
        code_a = a;
        code_b = b;
        settings_used++;
    endtask

    // mostly the live codes, now and then a stranger
    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return code_a;
        else if (r < 85)
            return code_b;
        return KIND_W'($urandom_range(0, 65535));
    endfunction

    // small sizes mostly, with full-range and all-ones sizes to hit bucket saturation
    function automatic logic [BYTES_W-1:0] pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return BYTES_W'($urandom_range(0, 65535));
        else if (r < 82)
            return BYTES_W'($urandom);
        else if (r < 95)
            return '1;
        return '0;
    endfunction

    // traffic clock: mostly creeps forward inside a few minutes, sometimes jumps a day
    // on to the same bucket near its expiry edge, rarely leaps or steps back
    task automatic advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            clock_now += NOW_W'($urandom_range(0, 20));
        else if (r < 90)
            clock_now += NOW_W'($urandom_range(20, 300));
        else if (r < 97)
            clock_now += NOW_W'(EXPIRY_SECONDS - $urandom_range(0, 120));
        else if (r < 99)
            clock_now += NOW_W'($urandom_range(0, 2000000));
        else
            clock_now -= NOW_W'($urandom_range(0, EXPIRY_SECONDS));
    endtask

    // a stretch of random traffic; unused-command beats do not count towards it
    task automatic random_traffic(input int n_items);
        int               made;
        int               r;
        logic [NOW_W-1:0] t;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(0, 19) == 0)
                steady = !steady;
            advance_clock();
            // occasional noise: a time from anywhere in the range
            t = ($urandom_range(0, 19) == 0) ? NOW_W'($urandom) : clock_now;
            r = $urandom_range(0, 99);
            if (r < 58)
                offer_beat(CMD_COUNT, t, pick_kind(), pick_bytes());
            else if (r < 70)
                offer_beat(CMD_ERROR, t, pick_kind(), pick_bytes());
            else if (r < 94)
                offer_beat(CMD_REPORT, t, pick_kind(), pick_bytes());
            else
                offer_beat(CMD_UNUSED, t, pick_kind(), pick_bytes());
            if (r < 94)
                made++;
        end
    endtask

    initial
    begin : stimulus
        int k;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_KIND_A;
        cfg_data              <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.cmd           <= CMD_COUNT;
        item_ch.now_seconds   <= '0;
        item_ch.message_kind  <= '0;
        item_ch.message_bytes <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset codes, kind A 0 and kind B 1
        // empty ring, bucket 0 so the previous bucket wraps to the top
        offer_beat(CMD_REPORT, 32'd0, 16'd0, 32'd0);
        // two all-ones sizes into one bucket: byte count saturates
        offer_beat(CMD_COUNT, 32'd30, 16'd0, '1);
        offer_beat(CMD_COUNT, 32'd45, 16'd0, '1);
        offer_beat(CMD_COUNT, 32'd59, 16'd1, 32'd0);
        // unknown kind counts nothing
        offer_beat(CMD_COUNT, 32'd50, 16'hFFFF, 32'd123);
        offer_beat(CMD_ERROR, 32'd10, 16'd0, 32'd0);
        // unused command with every field at all ones
        offer_beat(CMD_UNUSED, '1, '1, '1);
        offer_beat(CMD_REPORT, 32'd60, 16'd0, 32'd0);
        // last bucket while nothing can expire yet
        offer_beat(CMD_COUNT, 32'd86399, 16'd1, 32'h8000_0000);
        offer_beat(CMD_REPORT, 32'd86430, 16'd0, 32'd0);
        // bucket 0 goes stale: cleared and restamped at 86430
        offer_beat(CMD_COUNT, 32'd86430, 16'd0, 32'd77);
        // one second short of expiry, then exactly on it
        offer_beat(CMD_COUNT, 32'd172829, 16'd1, 32'd5);
        offer_beat(CMD_COUNT, 32'd172830, 16'd1, 32'd6);
        // stamp now lies in the future: never expires
        offer_beat(CMD_COUNT, 32'd40, 16'd0, 32'd9);
        offer_beat(CMD_ERROR, 32'd40, 16'd0, 32'd0);
        offer_beat(CMD_REPORT, 32'd90, 16'd0, 32'd0);
        // top of the time range: stamp plus expiry runs past 32 bits
        offer_beat(CMD_ERROR, '1, 16'd1, 32'd0);
        offer_beat(CMD_COUNT, '1, 16'd0, '1);
        offer_beat(CMD_COUNT, '1, 16'd0, 32'd1);
        offer_beat(CMD_REPORT, '1, 16'd0, 32'd0);
        // a few buckets on: the short window still reaches the busy one
        offer_beat(CMD_REPORT, 32'd23400, 16'd0, 32'd0);

        // random traffic, one setting of the codes per stretch
        clock_now = NOW_W'($urandom_range(0, 200000));
        random_traffic(PHASE_ITEMS);

        write_codes(16'hFFFF, 16'h0000);
        steady = 1'b1;
        random_traffic(PHASE_ITEMS);

        // both codes equal: matching beats count as kind A only
        k = $urandom_range(0, 65535);
        write_codes(KIND_W'(k), KIND_W'(k));
        random_traffic(PHASE_ITEMS);

        // pressure: the result side stops while reports keep coming
        write_codes(KIND_W'($urandom_range(0, 65535)), KIND_W'($urandom_range(0, 65535)));
        steady = 1'b1;
        hold_len = HOLD_CYCLES;
        repeat (6)
        begin
            advance_clock();
            offer_beat(CMD_REPORT, clock_now, pick_kind(), pick_bytes());
        end
        steady = 1'b0;
        random_traffic(PHASE_ITEMS);

        write_codes(16'h0000, 16'hFFFF);
        random_traffic(PHASE_ITEMS);

        // drain, then give a trailing count beat time to land
        settle();

        $display("sent %0d count, %0d error, %0d report and %0d unused-command beats under %0d code settings",
                 sent_count[CMD_COUNT], sent_count[CMD_ERROR], sent_count[CMD_REPORT],
                 sent_count[CMD_UNUSED], settings_used);
        $display("checked %0d report beats, including a %0d-cycle hold on the result side",
                 reports_checked, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("per_minute_traffic_window_stats_core test passed");
        else
            $display("per_minute_traffic_window_stats_core test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/pmtws_pkg.sv
rtl/core/pmtws_ifs.sv
rtl/core/pmtws_slot.sv
rtl/core/pmtws_dp.sv
rtl/core/pmtws_ctrl.sv
rtl/core/per_minute_traffic_window_stats_core.sv
test/pmtws_window_checker.sv
test/per_minute_traffic_window_stats_core_test.sv
